// ----- src/lru_cache_set_controller_macros.svh -----
// Assertion macros shared by the checker of the cache set controller.
// Standalone header; the including file supplies the signals it names.
`ifndef LRU_CACHE_SET_CONTROLLER_MACROS_SVH
`define LRU_CACHE_SET_CONTROLLER_MACROS_SVH

// Check a property on every rising edge, ignored while reset is high
`define LCS_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("cache set controller check failed");

// Check a property on every rising edge, reset included
`define LCS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("cache set controller check failed during reset");

`endif

// ----- src/lcs_pkg.sv -----
// Package of the cache set controller: sizes, codes and the cell-chain types.
// No dependencies; imported by the interfaces, the cells and the top level.
package lcs_pkg;

  localparam int WAYS      = 8;
  localparam int TAG_BITS  = 20;
  localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CNT_W     = $clog2(WAYS + 1);
  localparam int IN_TAG_W  = 20;
  localparam int OUTCOME_W = 2;
  localparam int OUT_WAY_W = 3;
  localparam int OUT_CNT_W = 4;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_HIT        = 2'd0,
    OUT_MISS_CLEAN = 2'd1,
    OUT_MISS_DIRTY = 2'd2
  } outcome_t;

  // Carry handed from one way cell to the next
  typedef struct packed {
    logic             hit;
    logic [WAY_W-1:0] hit_way;
    logic [WAY_W-1:0] hit_rank;
    logic             hit_dirty;
    logic             free;
    logic [WAY_W-1:0] free_way;
    logic [WAY_W-1:0] free_rank;
    logic             old_seen;
    logic [WAY_W-1:0] old_way;
    logic [WAY_W-1:0] old_rank;
    logic             old_dirty;
  } lcs_chain_t;

  // Lookup tag and update command broadcast to every cell
  typedef struct packed {
    logic                tag_en;
    logic [TAG_BITS-1:0] tag;
    logic                en;
    logic                hit;
    logic                write;
    logic [WAY_W-1:0]    way;
    logic [WAY_W-1:0]    rank;
  } lcs_upd_t;

endpackage

// ----- src/lcs_in_if.sv -----
// Access channel of the cache set controller: valid, ready and the item.
// Depends on lcs_pkg.
interface lcs_in_if import lcs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                operation;
  logic [IN_TAG_W-1:0] tag;

  modport source (output valid, operation, tag, input ready);
  modport sink (input valid, operation, tag, output ready);
endinterface

// ----- src/lcs_out_if.sv -----
// Result channel of the cache set controller: valid, ready and the item.
// Depends on lcs_pkg.
interface lcs_out_if import lcs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OUTCOME_W-1:0] outcome;
  logic [OUT_WAY_W-1:0] way;
  logic [OUT_CNT_W-1:0] dirty_count;

  modport source (output valid, outcome, way, dirty_count, input ready);
  modport sink (input valid, outcome, way, dirty_count, output ready);
endinterface

// ----- src/lcs_way_cell.sv -----
// One way of the set: tag, valid, dirty and recency rank, plus its link in
// the lookup chain. Depends on lcs_pkg.
module lcs_way_cell import lcs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [WAY_W-1:0] idx,
  input  lcs_upd_t         upd,
  input  lcs_chain_t       chain_in,
  output lcs_chain_t       chain_out
);

  logic [TAG_BITS-1:0] tag;
  logic                valid;
  logic                dirty;
  logic [WAY_W-1:0]    rank;
  logic                match;

  assign match = upd.tag_en && valid && (tag == upd.tag);

  // Pass the carry on, claiming the first hit, the first free way and the oldest way
  always_comb begin
    chain_out = chain_in;
    if (!chain_in.hit && match) begin
      chain_out.hit       = 1'b1;
      chain_out.hit_way   = idx;
      chain_out.hit_rank  = rank;
      chain_out.hit_dirty = dirty;
    end
    if (!chain_in.free && !valid) begin
      chain_out.free      = 1'b1;
      chain_out.free_way  = idx;
      chain_out.free_rank = rank;
    end
    if (!chain_in.old_seen || (rank > chain_in.old_rank)) begin
      chain_out.old_seen  = 1'b1;
      chain_out.old_way   = idx;
      chain_out.old_rank  = rank;
      chain_out.old_dirty = dirty;
    end
  end

  // Fill or touch the chosen way; age every way more recent than it
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      dirty <= 1'b0;
      rank  <= idx;
    end else if (upd.en) begin
      if (upd.way == idx) begin
        rank <= '0;
        if (upd.hit) begin
          dirty <= dirty | upd.write;
        end else begin
          tag   <= upd.tag;
          valid <= 1'b1;
          dirty <= upd.write;
        end
      end else if (rank < upd.rank) begin
        rank <= rank + 1'b1;
      end
    end
  end

endmodule

// ----- src/lru_cache_set_controller.sv -----
// Top level of the cache set controller: item register, way cell chain,
// result register. Depends on lcs_pkg, lcs_in_if, lcs_out_if, lcs_way_cell.
//
//   channel  | dir | fields                         | handshake
//   access   | in  | operation, tag                 | valid/ready
//   result   | out | outcome, way, dirty_count      | valid/ready
//
// Each item is captured in the item register; once the result register is
// free, the way cell chain resolves hit, free way and LRU victim and every
// cell updates. Reset (synchronous) clears valid and dirty bits and sets
// each rank to its way index; stored tags are not cleared.
// A stalled result holds; one more item is captured meanwhile, after which
// access.ready stays low until the result is taken.
module lru_cache_set_controller import lcs_pkg::*; (
  input logic     clk,
  input logic     rst,
  lcs_in_if.sink  access,
  lcs_out_if.source result
);

  logic                busy;
  logic                item_op;
  logic [TAG_BITS-1:0] item_tag;
  logic [CNT_W-1:0]    cnt;
  logic [CNT_W-1:0]    cnt_next;
  logic                fire;
  lcs_chain_t          chain [WAYS+1];
  lcs_chain_t          last;
  lcs_upd_t            upd;
  logic [WAY_W-1:0]    sel_way;
  logic [WAY_W-1:0]    sel_rank;
  logic                sel_dirty;
  logic                new_dirty;
  outcome_t            outcome;

  assign access.ready = !busy;
  assign fire         = busy && (!result.valid || result.ready);

  // Build the way cell chain
  assign chain[0] = '0;
  for (genvar i = 0; i < WAYS; i++) begin : g_way
    lcs_way_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .idx       (WAY_W'(i)),
      .upd       (upd),
      .chain_in  (chain[i]),
      .chain_out (chain[i+1])
    );
  end
  assign last = chain[WAYS];

  // Pick the way: hit, else first free, else least recent
  always_comb begin
    new_dirty = (item_op == OP_WRITE);
    if (last.hit) begin
      sel_way   = last.hit_way;
      sel_rank  = last.hit_rank;
      sel_dirty = last.hit_dirty;
      new_dirty = last.hit_dirty | (item_op == OP_WRITE);
      outcome   = OUT_HIT;
    end else if (last.free) begin
      sel_way   = last.free_way;
      sel_rank  = last.free_rank;
      sel_dirty = 1'b0;
      outcome   = OUT_MISS_CLEAN;
    end else begin
      sel_way   = last.old_way;
      sel_rank  = last.old_rank;
      sel_dirty = last.old_dirty;
      outcome   = last.old_dirty ? OUT_MISS_DIRTY : OUT_MISS_CLEAN;
    end
    cnt_next = cnt - CNT_W'(sel_dirty) + CNT_W'(new_dirty);
  end

  // Broadcast lookup tag and update command
  always_comb begin
    upd.tag_en = busy;
    upd.tag    = item_tag;
    upd.en     = fire;
    upd.hit    = last.hit;
    upd.write  = (item_op == OP_WRITE);
    upd.way    = sel_way;
    upd.rank   = sel_rank;
  end

  // Capture the item, hold the dirty count, drive the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      cnt          <= '0;
      result.valid <= 1'b0;
    end else begin
      if (access.valid && access.ready) begin
        busy     <= 1'b1;
        item_op  <= access.operation;
        item_tag <= TAG_BITS'(access.tag);
      end else if (fire) begin
        busy <= 1'b0;
      end
      if (fire) begin
        cnt                <= cnt_next;
        result.valid       <= 1'b1;
        result.outcome     <= outcome;
        result.way         <= OUT_WAY_W'(sel_way);
        result.dirty_count <= OUT_CNT_W'(cnt_next);
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

endmodule

// ----- src/lcs_checker.sv -----
// Port-level checks of the cache set controller, bound to its top level.
// Depends on lcs_pkg and lru_cache_set_controller_macros.svh.
`include "lru_cache_set_controller_macros.svh"

module lcs_checker import lcs_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [OUTCOME_W-1:0] out_outcome,
  input logic [OUT_WAY_W-1:0] out_way,
  input logic [OUT_CNT_W-1:0] out_dirty_count
);

  // No result right after reset
  `LCS_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid)
  // An item taken with the result side empty passes the item register, then the result register
  `LCS_ASSERT(a_latency, clk, rst, (in_valid && in_ready && !out_valid) |=> ##1 out_valid)
  // Outcome code three never appears
  `LCS_ASSERT(a_outcome_code, clk, rst, out_valid |-> (out_outcome != 2'd3))
  // A stalled result holds
  `LCS_ASSERT(a_hold, clk, rst, (out_valid && !out_ready) |=> (out_valid && $stable(out_outcome) && $stable(out_way) && $stable(out_dirty_count)))

endmodule

bind lru_cache_set_controller lcs_checker u_lcs_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (access.valid),
  .in_ready        (access.ready),
  .out_valid       (result.valid),
  .out_ready       (result.ready),
  .out_outcome     (result.outcome),
  .out_way         (result.way),
  .out_dirty_count (result.dirty_count)
);

// ----- sim/tb.sv -----
// Testbench of the cache set controller: random and directed read/write accesses,
// a local LRU set predictor and a scoreboard of predicted results.
// Depends on lcs_pkg, lcs_in_if, lcs_out_if and lru_cache_set_controller.
module tb;
  import lcs_pkg::*;

  localparam int NUM_ACCESSES = 1850;
  localparam int STALL_LIMIT  = 2000;
  localparam int SETTLE_CYCLES = 16;
  localparam logic [IN_TAG_W-1:0] TAG_MAX = {IN_TAG_W{1'b1}};

  typedef struct {
    logic                op;
    logic [IN_TAG_W-1:0] tag;
    bit                  drain;
  } access_item_t;

  typedef struct packed {
    outcome_t             outcome;
    logic [OUT_WAY_W-1:0] way;
    logic [OUT_CNT_W-1:0] dirty_count;
  } lookup_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lcs_in_if  access_bus ();
  lcs_out_if result_bus ();

  lru_cache_set_controller dut (
    .clk    (clk),
    .rst    (rst),
    .access (access_bus),
    .result (result_bus)
  );

  // Local copy of the set
  logic [TAG_BITS-1:0] line_tag   [WAYS];
  bit                  line_valid [WAYS];
  bit                  line_dirty [WAYS];
  int unsigned         line_rank  [WAYS];

  access_item_t   access_queue [$];
  lookup_result_t predicted_results [$];

  int total_accesses;
  int accesses_taken;
  int results_checked;
  int mismatches;
  int stall_cycles;
  int hit_count;
  int clean_miss_count;
  int dirty_evict_count;

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(string msg);
    $display("[%0t] result %0d: %s", $realtime, results_checked, msg);
    mismatches++;
  endtask

  task automatic add_access(logic op, logic [IN_TAG_W-1:0] tag, bit drain);
    access_item_t item;
    item.op = op;
    item.tag = tag;
    item.drain = drain;
    access_queue = {access_queue, item};
  endtask

  // Idle phase from progress: sender-light, receiver-light, then no idling
  function automatic int idle_phase(int done);
    if (done * 3 >= total_accesses * 2) return 2;
    if (done * 3 >= total_accesses) return 1;
    return 0;
  endfunction

  // Apply one access to the local set and return the result it causes
  function automatic lookup_result_t predict_access(logic op, logic [IN_TAG_W-1:0] tag_in);
    logic [TAG_BITS-1:0] key;
    int i;
    int way_sel;
    int old_rank;
    int dirty_total;
    bit hit;
    bit free_found;
    lookup_result_t r;
    key = TAG_BITS'(tag_in);
    way_sel = 0;
    hit = 1'b0;
    free_found = 1'b0;
    r.outcome = OUT_HIT;
    // Compare against every valid way, lowest match wins
    for (i = 0; i < WAYS; i++) begin
      if (!hit && line_valid[i] && line_tag[i] == key) begin
        hit = 1'b1;
        way_sel = i;
      end
    end
    if (hit) begin
      if (op == OP_WRITE) line_dirty[way_sel] = 1'b1;
    end else begin
      r.outcome = OUT_MISS_CLEAN;
      for (i = 0; i < WAYS; i++) begin
        if (!free_found && !line_valid[i]) begin
          free_found = 1'b1;
          way_sel = i;
        end
      end
      // Set full: evict the least recent way
      if (!free_found) begin
        way_sel = 0;
        for (i = 1; i < WAYS; i++) begin
          if (line_rank[i] > line_rank[way_sel]) way_sel = i;
        end
        if (line_dirty[way_sel]) r.outcome = OUT_MISS_DIRTY;
      end
      line_tag[way_sel] = key;
      line_valid[way_sel] = 1'b1;
      line_dirty[way_sel] = (op == OP_WRITE);
    end
    // Promote the touched way, age the ones more recent than it
    old_rank = line_rank[way_sel];
    for (i = 0; i < WAYS; i++) begin
      if (line_rank[i] < old_rank) line_rank[i]++;
    end
    line_rank[way_sel] = 0;
    dirty_total = 0;
    for (i = 0; i < WAYS; i++) dirty_total += line_dirty[i];
    r.way = OUT_WAY_W'(way_sel);
    r.dirty_count = OUT_CNT_W'(dirty_total);
    return r;
  endfunction

  // Drive accesses from the queue; predict each accepted item
  always @(posedge clk) begin : drive_access
    access_item_t item;
    int idle_pct;
    if (rst) begin
      access_bus.valid <= 1'b0;
    end else begin
      if (access_bus.valid && access_bus.ready) begin
        predicted_results = {predicted_results,
                             predict_access(access_bus.operation, access_bus.tag)};
        accesses_taken++;
      end
      if (!access_bus.valid || access_bus.ready) begin
        case (idle_phase(accesses_taken))
          0: idle_pct = 11;
          1: idle_pct = 88;
          default: idle_pct = 0;
        endcase
        if (access_queue.size() == 0 ||
            (access_queue[0].drain && predicted_results.size() != 0) ||
            $urandom_range(99) < idle_pct) begin
          access_bus.valid <= 1'b0;
        end else begin
          item = access_queue.pop_front();
          access_bus.valid <= 1'b1;
          access_bus.operation <= item.op;
          access_bus.tag <= item.tag;
        end
      end
    end
  end

  // Check each accepted result against the oldest prediction
  always @(posedge clk) begin : check_result
    lookup_result_t want;
    int idle_pct;
    if (rst) begin
      result_bus.ready <= 1'b0;
    end else begin
      if (result_bus.valid && result_bus.ready) begin
        if (predicted_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result outcome=%0d way=%0d dirty_count=%0d",
                                    result_bus.outcome, result_bus.way,
                                    result_bus.dirty_count));
        end else begin
          want = predicted_results.pop_front();
          if (result_bus.outcome !== want.outcome)
            report_mismatch($sformatf("outcome got %0d want %0d",
                                      result_bus.outcome, want.outcome));
          if (result_bus.way !== want.way)
            report_mismatch($sformatf("way got %0d want %0d", result_bus.way, want.way));
          if (result_bus.dirty_count !== want.dirty_count)
            report_mismatch($sformatf("dirty_count got %0d want %0d",
                                      result_bus.dirty_count, want.dirty_count));
          case (want.outcome)
            OUT_HIT:        hit_count++;
            OUT_MISS_CLEAN: clean_miss_count++;
            default:        dirty_evict_count++;
          endcase
        end
        results_checked++;
      end
      case (idle_phase(results_checked))
        0: idle_pct = 88;
        1: idle_pct = 11;
        default: idle_pct = 0;
      endcase
      result_bus.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Count cycles in which neither channel moves an item
  always @(posedge clk) begin
    if (rst || (access_bus.valid && access_bus.ready) ||
        (result_bus.valid && result_bus.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    logic [IN_TAG_W-1:0] tag_pool [16];
    logic [IN_TAG_W-1:0] tag;
    int i;
    int j;
    int pool_size;
    int burst_len;
    int pick;
    bit pause;
    bit first_burst;

    access_bus.valid = 1'b0;
    access_bus.operation = OP_READ;
    access_bus.tag = '0;
    result_bus.ready = 1'b0;
    for (i = 0; i < WAYS; i++) begin
      line_tag[i] = '0;
      line_valid[i] = 1'b0;
      line_dirty[i] = 1'b0;
      line_rank[i] = i;
    end

    // Directed: extreme tags, hits of both kinds, fill every way
    add_access(OP_READ,  '0, 1'b0);
    add_access(OP_WRITE, TAG_MAX, 1'b0);
    add_access(OP_READ,  '0, 1'b0);
    add_access(OP_WRITE, '0, 1'b0);
    add_access(OP_READ,  TAG_MAX, 1'b0);
    add_access(OP_WRITE, 20'h00001, 1'b0);
    add_access(OP_READ,  20'h00002, 1'b0);
    add_access(OP_WRITE, 20'h00003, 1'b0);
    add_access(OP_READ,  20'h00004, 1'b0);
    add_access(OP_WRITE, 20'h00005, 1'b0);
    add_access(OP_READ,  20'h00006, 1'b0);
    // Full set: dirty victims, a clean victim, new-line hits, then one of each
    add_access(OP_READ,  20'h80000, 1'b0);
    add_access(OP_READ,  20'h55555, 1'b0);
    add_access(OP_WRITE, 20'h2AAAA, 1'b0);
    add_access(OP_READ,  20'hFFFFE, 1'b0);
    add_access(OP_READ,  20'h80000, 1'b0);
    add_access(OP_WRITE, 20'h55555, 1'b0);
    add_access(OP_READ,  20'h00001, 1'b0);
    add_access(OP_WRITE, 20'h00006, 1'b0);
    add_access(OP_WRITE, 20'h7FFFF, 1'b0);

    // Random: bursts over a small working set, with fresh and edge tags mixed in
    first_burst = 1'b1;
    while (access_queue.size() < NUM_ACCESSES) begin
      pool_size = $urandom_range(14, 2);
      for (i = 0; i < pool_size; i++) tag_pool[i] = IN_TAG_W'($urandom);
      burst_len = $urandom_range(80, 20);
      pause = first_burst || ($urandom_range(9) == 0);
      first_burst = 1'b0;
      for (j = 0; j < burst_len && access_queue.size() < NUM_ACCESSES; j++) begin
        pick = $urandom_range(99);
        if (pick < 85) begin
          tag = tag_pool[$urandom_range(pool_size - 1)];
        end else if (pick < 95) begin
          tag = IN_TAG_W'($urandom);
        end else begin
          case ($urandom_range(2))
            0: tag = '0;
            1: tag = TAG_MAX;
            default: tag = IN_TAG_W'(1) << $urandom_range(IN_TAG_W - 1);
          endcase
        end
        add_access(logic'($urandom_range(1)), tag, pause && j == 0);
      end
    end
    total_accesses = access_queue.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Wait until every access is taken and every result checked
    while (access_queue.size() != 0 || access_bus.valid || predicted_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d accesses through an %0d-way set: %0d hits, %0d clean fills,",
             accesses_taken, WAYS, hit_count, clean_miss_count);
    $display("%0d dirty evictions, %0d results checked, %0d mismatches",
             dirty_evict_count, results_checked, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
